// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define AST_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also holds during reset
`define AST_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/abdd_pkg.sv -----
package abdd_pkg;

  // default grid size
  localparam int GRID_ROWS_DEF = 64;
  localparam int GRID_COLS_DEF = 64;

  // log2(e) in Q.16
  localparam int LOG2E_Q16 = 94548;

  // register map
  typedef enum logic [2:0] {
    REG_IMG_H  = 3'd0,
    REG_IMG_W  = 3'd1,
    REG_MIN_H  = 3'd2,
    REG_MIN_W  = 3'd3,
    REG_STRIDE = 3'd4
  } abdd_reg_e;

  // register reset values
  localparam logic [12:0] IMG_H_RST  = 13'd600;
  localparam logic [12:0] IMG_W_RST  = 13'd1000;
  localparam logic [15:0] MIN_H_RST  = 16'd128;
  localparam logic [15:0] MIN_W_RST  = 16'd128;
  localparam logic [6:0]  STRIDE_RST = 7'd16;

  // stage load enables for the exp pipeline
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } abdd_en_t;

  // 2^(idx/16) in Q.16 for idx 0..16, 2.0 above that
  function automatic logic [17:0] pow2_lut(input logic [4:0] idx);
    logic [17:0] v;
    case (idx)
      5'd0:    v = 18'd65536;
      5'd1:    v = 18'd68438;
      5'd2:    v = 18'd71468;
      5'd3:    v = 18'd74632;
      5'd4:    v = 18'd77936;
      5'd5:    v = 18'd81386;
      5'd6:    v = 18'd84990;
      5'd7:    v = 18'd88752;
      5'd8:    v = 18'd92682;
      5'd9:    v = 18'd96785;
      5'd10:   v = 18'd101070;
      5'd11:   v = 18'd105545;
      5'd12:   v = 18'd110218;
      5'd13:   v = 18'd115098;
      5'd14:   v = 18'd120194;
      5'd15:   v = 18'd125515;
      default: v = 18'd131072;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/anchor_box_delta_decode.sv -----
// an accepted input transaction passes through the stage 1 to stage 7 registers to its result at the outputs
// throughput: one transaction per cycle while the output is not stalled, set by the seven-stage register pipeline
// a stage holds only while its successor is full and the output is stalled
// reset (rst_ni low, asynchronous) empties the pipeline and loads the register defaults
module anchor_box_delta_decode import abdd_pkg::*; #(
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [5:0]         cell_row_i,
  input  logic [5:0]         cell_col_i,
  input  logic signed [15:0] anchor_left_i,
  input  logic signed [15:0] anchor_top_i,
  input  logic signed [15:0] anchor_right_i,
  input  logic signed [15:0] anchor_bottom_i,
  input  logic signed [15:0] delta_x_i,
  input  logic signed [15:0] delta_y_i,
  input  logic signed [15:0] delta_log_w_i,
  input  logic signed [15:0] delta_log_h_i,
  input  logic [15:0]        fg_score_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        box_left_o,
  output logic [15:0]        box_top_o,
  output logic [15:0]        box_right_o,
  output logic [15:0]        box_bottom_o,
  output logic [15:0]        masked_score_o,
  output logic               keep_flag_o
);

  localparam logic [10:0] ROW_MAX = 11'(GRID_ROWS - 1);
  localparam logic [10:0] COL_MAX = 11'(GRID_COLS - 1);

  function automatic logic [15:0] clip16(input logic signed [34:0] v,
                                         input logic signed [17:0] hi);
    logic signed [34:0] t;
    t = v;
    if (t > 35'(hi)) t = 35'(hi);
    if (t < 35'sd0) t = 35'sd0;
    return t[15:0];
  endfunction

  // configuration registers
  logic [12:0] img_h_q, img_w_q;
  logic [15:0] min_h_q, min_w_q;
  logic [6:0]  stride_q;
  abdd_reg_e   reg_sel;
  logic        wr_en;

  assign reg_sel = abdd_reg_e'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_h_q  <= IMG_H_RST;
      img_w_q  <= IMG_W_RST;
      min_h_q  <= MIN_H_RST;
      min_w_q  <= MIN_W_RST;
      stride_q <= STRIDE_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_IMG_H:  img_h_q  <= pwdata[12:0];
        REG_IMG_W:  img_w_q  <= pwdata[12:0];
        REG_MIN_H:  min_h_q  <= pwdata[15:0];
        REG_MIN_W:  min_w_q  <= pwdata[15:0];
        REG_STRIDE: stride_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    unique case (reg_sel)
      REG_IMG_H:  prdata = {19'd0, img_h_q};
      REG_IMG_W:  prdata = {19'd0, img_w_q};
      REG_MIN_H:  prdata = {16'd0, min_h_q};
      REG_MIN_W:  prdata = {16'd0, min_w_q};
      REG_STRIDE: prdata = {25'd0, stride_q};
      default:    prdata = 32'd0;
    endcase
  end

  // pipeline flow control
  logic [7:1] v_q;
  logic [7:1] en;
  abdd_en_t   exp_en;

  always_comb begin
    en[7] = !v_q[7] || !out_stall_i;
    for (int k = 6; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[1];
  assign exp_en      = '{en1: en[1], en2: en[2], en3: en[3]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_valid_i;
      for (int k = 2; k <= 7; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: cell offsets
  logic [5:0]         row_c, col_c;
  logic [12:0]        ox_q, oy_q;
  logic signed [15:0] al_q, at_q, ar_q, ab_q, dx1_q, dy1_q;
  logic [15:0]        sc1_q;

  always_comb begin
    row_c = ({5'd0, cell_row_i} > ROW_MAX) ? ROW_MAX[5:0] : cell_row_i;
    col_c = ({5'd0, cell_col_i} > COL_MAX) ? COL_MAX[5:0] : cell_col_i;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      ox_q  <= 13'({7'd0, col_c} * {6'd0, stride_q});
      oy_q  <= 13'({7'd0, row_c} * {6'd0, stride_q});
      al_q  <= anchor_left_i;
      at_q  <= anchor_top_i;
      ar_q  <= anchor_right_i;
      ab_q  <= anchor_bottom_i;
      dx1_q <= delta_x_i;
      dy1_q <= delta_y_i;
      sc1_q <= fg_score_i;
    end
  end

  // exp of the log deltas, aligned with stage 3
  logic [31:0] ew, eh;

  abdd_exp u_exp_w (.clk_i, .en_i(exp_en), .d_i(delta_log_w_i), .e_o(ew));
  abdd_exp u_exp_h (.clk_i, .en_i(exp_en), .d_i(delta_log_h_i), .e_o(eh));

  // stage 2: corners and size
  logic signed [18:0] x1, y1, x2, y2;
  logic signed [18:0] x1_q, y1_q;
  logic signed [17:0] w2_q, h2_q;
  logic signed [15:0] dx2_q, dy2_q;
  logic [15:0]        sc2_q;

  always_comb begin
    x1 = $signed({2'b00, ox_q, 4'b0000}) + 19'(al_q);
    x2 = $signed({2'b00, ox_q, 4'b0000}) + 19'(ar_q);
    y1 = $signed({2'b00, oy_q, 4'b0000}) + 19'(at_q);
    y2 = $signed({2'b00, oy_q, 4'b0000}) + 19'(ab_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      x1_q  <= x1;
      y1_q  <= y1;
      w2_q  <= 18'(x2 - x1 + 19'sd16);
      h2_q  <= 18'(y2 - y1 + 19'sd16);
      dx2_q <= dx1_q;
      dy2_q <= dy1_q;
      sc2_q <= sc1_q;
    end
  end

  // stage 3: doubled center and delta products
  logic signed [20:0] cx_q, cy_q;
  logic signed [33:0] dxw_q, dyh_q;
  logic signed [17:0] w3_q, h3_q;
  logic [15:0]        sc3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      cx_q  <= (21'(x1_q) <<< 1) + 21'(w2_q);
      cy_q  <= (21'(y1_q) <<< 1) + 21'(h2_q);
      dxw_q <= 34'(dx2_q) * 34'(w2_q);
      dyh_q <= 34'(dy2_q) * 34'(h2_q);
      w3_q  <= w2_q;
      h3_q  <= h2_q;
      sc3_q <= sc2_q;
    end
  end

  // stage 4: predicted center and scaled size
  logic signed [38:0] pcx_q, pcy_q;
  logic signed [50:0] pw_q, ph_q;
  logic [15:0]        sc4_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      pcx_q <= (39'(cx_q) <<< 15) + (39'(dxw_q) <<< 4);
      pcy_q <= (39'(cy_q) <<< 15) + (39'(dyh_q) <<< 4);
      pw_q  <= 51'($signed({1'b0, ew})) * 51'(w3_q);
      ph_q  <= 51'($signed({1'b0, eh})) * 51'(h3_q);
      sc4_q <= sc3_q;
    end
  end

  // stage 5: corners rounded to Q.4
  logic signed [51:0] vl, vr, vt, vb;
  logic signed [34:0] rl_q, rr_q, rt_q, rb_q;
  logic [15:0]        sc5_q;

  always_comb begin
    vl = (52'(pcx_q) <<< 1) - 52'(pw_q) + 52'sd65536;
    vr = (52'(pcx_q) <<< 1) + 52'(pw_q) + 52'sd65536;
    vt = (52'(pcy_q) <<< 1) - 52'(ph_q) + 52'sd65536;
    vb = (52'(pcy_q) <<< 1) + 52'(ph_q) + 52'sd65536;
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      rl_q  <= 35'(vl >>> 17);
      rr_q  <= 35'(vr >>> 17);
      rt_q  <= 35'(vt >>> 17);
      rb_q  <= 35'(vb >>> 17);
      sc5_q <= sc4_q;
    end
  end

  // stage 6: clip to image
  logic signed [17:0] hx_raw, hy_raw, hx, hy;
  logic [15:0]        bl_q, br_q, bt_q, bb_q, sc6_q;

  always_comb begin
    hx_raw = $signed({1'b0, img_w_q, 4'b0000}) - 18'sd16;
    hy_raw = $signed({1'b0, img_h_q, 4'b0000}) - 18'sd16;
    hx     = (hx_raw > 18'sd65535) ? 18'sd65535 : hx_raw;
    hy     = (hy_raw > 18'sd65535) ? 18'sd65535 : hy_raw;
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      bl_q  <= clip16(rl_q, hx);
      br_q  <= clip16(rr_q, hx);
      bt_q  <= clip16(rt_q, hy);
      bb_q  <= clip16(rb_q, hy);
      sc6_q <= sc5_q;
    end
  end

  // stage 7: minimum size test and output register
  logic signed [17:0] cw, ch;
  logic               keep;

  always_comb begin
    cw   = $signed({2'b00, br_q}) - $signed({2'b00, bl_q}) + 18'sd16;
    ch   = $signed({2'b00, bb_q}) - $signed({2'b00, bt_q}) + 18'sd16;
    keep = (cw >= $signed({2'b00, min_w_q})) && (ch >= $signed({2'b00, min_h_q}));
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      box_left_o     <= bl_q;
      box_right_o    <= br_q;
      box_top_o      <= bt_q;
      box_bottom_o   <= bb_q;
      masked_score_o <= keep ? sc6_q : 16'd0;
      keep_flag_o    <= keep;
    end
  end

  assign out_valid_o = v_q[7];

endmodule

// ----- rtl/core/abdd_exp.sv -----
module abdd_exp import abdd_pkg::*; (
  input  logic               clk_i,
  input  abdd_en_t           en_i,
  input  logic signed [15:0] d_i,
  output logic [31:0]        e_o
);

  logic signed [34:0] t_q;
  logic signed [6:0]  k_q;
  logic [17:0]        base_q;
  logic [36:0]        prod_q;
  logic [31:0]        e_q;

  logic [3:0]  idx;
  logic [12:0] diff;
  logic [17:0] mant;
  logic [33:0] shl;
  logic [6:0]  n;
  logic [41:0] shr;
  logic [31:0] e_d;

  // stage 1: d times log2(e)
  always_ff @(posedge clk_i) begin
    if (en_i.en1) begin
      t_q <= 35'(d_i) * 35'(LOG2E_Q16);
    end
  end

  // stage 2: integer part, table base and interpolation product
  always_comb begin
    idx  = t_q[27:24];
    diff = 13'(pow2_lut({1'b0, idx} + 5'd1) - pow2_lut({1'b0, idx}));
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en2) begin
      k_q    <= t_q[34:28];
      base_q <= pow2_lut({1'b0, idx});
      prod_q <= 37'(diff) * 37'(t_q[23:0]);
    end
  end

  // stage 3: mantissa and scale by 2^k
  always_comb begin
    mant = base_q + 18'((38'(prod_q) + 38'h800000) >> 24);
    shl  = 34'(mant) << k_q[3:0];
    n    = 7'(-k_q);
    shr  = (42'(mant) + (42'd1 << (n[5:0] - 6'd1))) >> n[5:0];
    if (!k_q[6]) begin
      if (k_q > 7'sd15 || shl[33:32] != 2'b00) begin
        e_d = 32'hFFFF_FFFF;
      end else begin
        e_d = shl[31:0];
      end
    end else if (n > 7'd40) begin
      e_d = 32'd0;
    end else begin
      e_d = shr[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en3) begin
      e_q <= e_d;
    end
  end

  assign e_o = e_q;

endmodule

// ----- rtl/core/abdd_checker.sv -----
`include "assert_macros.svh"

module abdd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] box_left_o,
  input logic [15:0] box_top_o,
  input logic [15:0] box_right_o,
  input logic [15:0] box_bottom_o,
  input logic [15:0] masked_score_o,
  input logic        keep_flag_o
);

  // result payload as one vector
  logic [80:0] res_payload;

  assign res_payload = {box_left_o, box_top_o, box_right_o, box_bottom_o, masked_score_o,
                        keep_flag_o};

  // a stalled result transaction holds its payload
  `AST_CLK(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(res_payload), "stalled result changed")

  // a dropped box carries no score
  `AST_CLK(a_mask, out_valid_o && !keep_flag_o |-> masked_score_o == 16'd0, "score not masked")

  // input backpressure only comes from a full pipeline behind a stalled output
  `AST_CLK(a_stall_src, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without cause")

  // register port never waits
  `AST_CLK_ALWAYS(a_pready, pready, "pready low")

endmodule

bind anchor_box_delta_decode abdd_checker u_abdd_checker (.*);
